[hdl/sitda_pkg.sv]
package sitda_pkg;

    // width of the signed input value
    localparam int VALUE_WIDTH = 32;

    // decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
    localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W  = DIGITS * 4;
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W  = $clog2(DIGITS);

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_MINUS = 7'd45;
    localparam logic [6:0] ASCII_NINE  = 7'd57;

    // shift-add correction: a digit of five or more gets three added before the shift
    localparam logic [3:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [3:0] DIGIT_ADJ     = 4'd3;

    typedef logic [3:0] t_digit;

endpackage

[hdl/signed_int_to_decimal_ascii.sv]
// channel | direction | valid       | stall       | payload
// --------+-----------+-------------+-------------+----------------------------------
// in      | to block  | i_in_valid  | o_in_stall  | i_in_value (signed)
// out     | from block| o_out_valid | i_out_stall | o_out_character, o_out_last
//
// a value is loaded, shifted VALUE_WIDTH bits through the shared shift-add
// correction unit, the leading digit is found, and then one character per cycle
// is emitted while the output is not stalled (1 to DIGITS+1 characters)
// the input is taken only in idle; o_in_stall is high while a value is in work
// a stalled output holds the character register and the emit sequencer waits
// synchronous active-low reset clears the sequencer and the output valid

module signed_int_to_decimal_ascii (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic [sitda_pkg::VALUE_WIDTH-1:0] i_in_value,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output logic [6:0]                        o_out_character,
    output logic                              o_out_last,
    input  logic                              i_out_stall
);
    import sitda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_FIND = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    // sequencer state
    logic [1:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic                   r_neg, n_neg;
    logic                   r_sign_pend, n_sign_pend;

    // datapath: magnitude being shifted out and the bcd digit store
    logic [VALUE_WIDTH-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BCD_W-1:0]       w_bcd_step;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [6:0]             r_char, n_char;
    logic                   r_last, n_last;

    logic                   w_in_xfer;
    logic                   w_out_free;
    logic [IDX_W-1:0]       w_top;
    t_digit                 w_digit;

    sitda_dd_step u_step (
        .i_bcd (r_bcd),
        .i_bit (r_bin[VALUE_WIDTH-1]),
        .o_bcd (w_bcd_step)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    // output slot can take a character this cycle
    assign w_out_free = !r_out_valid || !i_out_stall;

    // highest nonzero digit, zero when the whole value is zero
    always_comb begin
        w_top = '0;
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[k*4 +: 4] != 4'd0) begin
                w_top = IDX_W'(k);
            end
        end
    end

    assign w_digit = r_bcd[r_idx*4 +: 4];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_neg       = r_neg;
        n_sign_pend = r_sign_pend;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;

        // output transfer frees the slot
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_neg = i_in_value[VALUE_WIDTH-1];
                    // the most negative value negates to itself, read unsigned
                    n_bin = i_in_value[VALUE_WIDTH-1] ? (~i_in_value + 1'b1) : i_in_value;
                    n_bcd = '0;
                    n_cnt = CNT_W'(VALUE_WIDTH);
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                // one bit per cycle through the correction unit
                n_bcd = w_bcd_step;
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                n_idx       = w_top;
                n_sign_pend = r_neg;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_sign_pend) begin
                        n_char      = ASCII_MINUS;
                        n_last      = 1'b0;
                        n_sign_pend = 1'b0;
                    end else begin
                        n_char = ASCII_ZERO + {3'b000, w_digit};
                        n_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_neg       <= 1'b0;
            r_sign_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_neg       <= n_neg;
            r_sign_pend <= n_sign_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_character = r_char;
    assign o_out_last      = r_last;

    // accepted value always starts a conversion
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_CONV) && (r_cnt == CNT_W'(VALUE_WIDTH)))
        else $error("accepted value did not start conversion");

    // conversion never runs with an exhausted bit count
    a_conv_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> (r_cnt != '0))
        else $error("conversion running with zero bit count");

    // minus sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_char == ASCII_MINUS)) |-> !r_last)
        else $error("minus sign flagged last");

    // every other character is a decimal digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_char != ASCII_MINUS)) |->
            ((r_char >= ASCII_ZERO) && (r_char <= ASCII_NINE)))
        else $error("character is not a decimal digit");

    // digit index stays within the digit store while emitting
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_idx <= IDX_W'(DIGITS - 1)))
        else $error("digit index outside store");

endmodule

[hdl/sitda_dd_step.sv]
module sitda_dd_step (
    input  logic [sitda_pkg::BCD_W-1:0] i_bcd,
    input  logic                        i_bit,
    output logic [sitda_pkg::BCD_W-1:0] o_bcd
);
    import sitda_pkg::*;

    logic [BCD_W-1:0] w_adj;

    // correct every digit, then shift in the next binary bit
    always_comb begin
        t_digit d;
        for (int k = 0; k < DIGITS; k++) begin
            d = i_bcd[k*4 +: 4];
            if (d >= DIGIT_ADJ_MIN) begin
                w_adj[k*4 +: 4] = d + DIGIT_ADJ;
            end else begin
                w_adj[k*4 +: 4] = d;
            end
        end
    end

    assign o_bcd = {w_adj[BCD_W-2:0], i_bit};

endmodule
